>>> rtl/texture_store_bilinear_sampler_core_assert.svh
// Assertion macros for the checker file of the texture sampler.
`ifndef TEXTURE_STORE_BILINEAR_SAMPLER_CORE_ASSERT_SVH
`define TEXTURE_STORE_BILINEAR_SAMPLER_CORE_ASSERT_SVH
// The consequent must hold in the cycle after the antecedent.
`define TSBS_ASSERT_NEXT(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define TSBS_ASSERT_SAME(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error(msg);
`endif

>>> rtl/tsbs_pkg.sv
`timescale 1ns / 1ps
package tsbs_pkg;

  localparam int DEF_MAX_SIDE     = 128;
  localparam int DEF_CHANNEL_BITS = 16;
  localparam int CALC_W           = 16;
  localparam int CHAN_W           = 16;
  localparam int SIDE_W           = 8;
  localparam int Q15_ONE          = 32768;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    CMD_WRITE_XY  = 3'd0,
    CMD_READ_XY   = 3'd1,
    CMD_NEAREST   = 3'd2,
    CMD_BILINEAR  = 3'd3,
    CMD_WRITE_LIN = 3'd4,
    CMD_READ_LIN  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    EK_WRITE,
    EK_READ,
    EK_BILIN
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t                  kind;
    logic                         zero;
    logic [3:0][CALC_W-1:0]       addr;
    logic [CHAN_W-1:0]            wgt_x;
    logic [CHAN_W-1:0]            wgt_y;
    logic [3:0][CHAN_W-1:0]       wdata;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_SQ,
    FS_CUBE,
    FS_WGT
  } front_state_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_WRITE,
    BS_FETCH,
    BS_LAST,
    BS_ROW,
    BS_MIX
  } back_state_t;

  // Smoothstep weight 3t^2 - 2t^3 in Q15, saturated to one.
  function automatic logic [CHAN_W-1:0] smooth_wgt(input logic [14:0] t2,
                                                   input logic [14:0] t3);
    logic [17:0] s;
    s = 18'(t2) * 18'd3 - 18'(t3) * 18'd2;
    return (s > 18'(Q15_ONE)) ? CHAN_W'(Q15_ONE) : s[CHAN_W-1:0];
  endfunction

endpackage

>>> rtl/texture_store_bilinear_sampler_core.sv
`timescale 1ns / 1ps
// Texture store with pixel access and nearest / bilinear sampling.
// Requests enter on start when busy is low; in_cmd selects write or read by
// column and row, nearest or bilinear sampling, or write or read by linear
// index. Image size registers are written through cfg_valid / cfg_ready
// (always ready), index 0 for width and 1 for height; the user must write
// them only while the block is idle, as the block does not enforce it.
// A front sequencer (a chain of registered multiplies) turns each
// request into store addresses and weights and queues it; a back sequencer
// drives the single-port pixel memory, one access per cycle.
// Results appear for one cycle on out_valid with the four channels; a
// bilinear sample is built from four fetches, then two blend steps.
// Busy stays high until the result is shown; the next request may enter in
// the cycle the result is on the ports. A write occupies the block until it
// is stored; an unknown command or a write outside the image only until the
// front sequencer drops it. The receiver cannot stall results.
// After reset the pixel store is cleared one entry per cycle, all MAX_SIDE^2
// entries, with busy high; the size registers return to 128.
module texture_store_bilinear_sampler_core
  import tsbs_pkg::*;
#(
  parameter int MAX_SIDE     = DEF_MAX_SIDE,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic [6:0]         in_col,
  input  logic [6:0]         in_row,
  input  logic [13:0]        in_linear_index,
  input  logic [15:0]        in_coord_u,
  input  logic [15:0]        in_coord_v,
  input  logic [CHAN_W-1:0]  in_red,
  input  logic [CHAN_W-1:0]  in_green,
  input  logic [CHAN_W-1:0]  in_blue,
  input  logic [CHAN_W-1:0]  in_alpha,
  output logic               out_valid,
  output logic [CHAN_W-1:0]  out_red,
  output logic [CHAN_W-1:0]  out_green,
  output logic [CHAN_W-1:0]  out_blue,
  output logic [CHAN_W-1:0]  out_alpha,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [SIDE_W-1:0]  cfg_data
);

  logic [SIDE_W-1:0] width_r, height_r;
  logic              accept, front_busy, back_busy, push, pop;
  entry_t            push_data, pop_data;
  q_stat_t           q_stat;
  logic [3:0][CHAN_W-1:0] wdata, out_chan;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = front_busy || !q_stat.empty || back_busy;
  assign wdata     = {in_alpha, in_blue, in_green, in_red};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_W'(128);
      height_r <= SIDE_W'(128);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data;
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tsbs_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_cmd),
    .col         (in_col),
    .row         (in_row),
    .linear_index(in_linear_index),
    .coord_u     (in_coord_u),
    .coord_v     (in_coord_v),
    .wdata       (wdata),
    .width_reg   (width_r),
    .height_reg  (height_r),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data),
    .busy        (front_busy)
  );

  tsbs_queue #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .stat     (q_stat)
  );

  tsbs_back #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .DEPTH       (MAX_SIDE * MAX_SIDE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_chan (out_chan),
    .busy     (back_busy)
  );

  assign out_red   = out_chan[0];
  assign out_green = out_chan[1];
  assign out_blue  = out_chan[2];
  assign out_alpha = out_chan[3];

endmodule

>>> rtl/tsbs_ram.sv
`timescale 1ns / 1ps
module tsbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> rtl/tsbs_queue.sv
`timescale 1ns / 1ps
module tsbs_queue
  import tsbs_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (PTR_W+1)'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tsbs_front.sv
`timescale 1ns / 1ps
module tsbs_front
  import tsbs_pkg::*;
#(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [2:0]         cmd,
  input  logic [6:0]         col,
  input  logic [6:0]         row,
  input  logic [13:0]        linear_index,
  input  logic [15:0]        coord_u,
  input  logic [15:0]        coord_v,
  input  logic [3:0][CHAN_W-1:0] wdata,
  input  logic [SIDE_W-1:0]  width_reg,
  input  logic [SIDE_W-1:0]  height_reg,
  input  q_stat_t            q_stat,
  output logic               push,
  output entry_t             push_data,
  output logic               busy
);

  localparam int SIDE_CAP = (MAX_SIDE > 255) ? 255 : MAX_SIDE;

  front_state_t state_r, state_nxt;

  logic [2:0]   cmd_r;
  logic [6:0]   col_r, row_r;
  logic [13:0]  lin_r;
  logic [15:0]  u_r, v_r;
  logic [3:0][CHAN_W-1:0] wd_r;
  logic [7:0]   w_r, h_r;
  logic [23:0]  sx_r, sy_r;
  logic [15:0]  rw_r, len_r;
  logic [14:0]  t2x_r, t2y_r, t3x_r, t3y_r;
  logic [7:0]   ix_r, iy_r, ix1_r, iy1_r, nx_r, ny_r;
  logic [15:0]  pix_r;
  logic         inside_r;
  logic [15:0]  yw0_r, yw1_r, nyw_r;

  logic [7:0]   w_side, h_side, wm1, hm1;
  logic [15:0]  u_sat, v_sat;
  logic [23:0]  nsx, nsy;
  logic [8:0]   ixp1, iyp1;
  logic [29:0]  px2, py2, px3, py3;
  logic         has_push;
  entry_t       ent;

  always_comb begin
    if (width_reg == '0) begin
      w_side = 8'd1;
    end else if (32'(width_reg) > SIDE_CAP) begin
      w_side = 8'(SIDE_CAP);
    end else begin
      w_side = width_reg;
    end
    if (height_reg == '0) begin
      h_side = 8'd1;
    end else if (32'(height_reg) > SIDE_CAP) begin
      h_side = 8'(SIDE_CAP);
    end else begin
      h_side = height_reg;
    end
  end

  assign u_sat = (coord_u > 16'(Q15_ONE)) ? 16'(Q15_ONE) : coord_u;
  assign v_sat = (coord_v > 16'(Q15_ONE)) ? 16'(Q15_ONE) : coord_v;
  assign wm1   = w_r - 8'd1;
  assign hm1   = h_r - 8'd1;
  assign nsx   = sx_r + 24'd16384;
  assign nsy   = sy_r + 24'd16384;
  assign ixp1  = {1'b0, sx_r[22:15]} + 9'd1;
  assign iyp1  = {1'b0, sy_r[22:15]} + 9'd1;
  assign px2   = 30'(sx_r[14:0]) * 30'(sx_r[14:0]);
  assign py2   = 30'(sy_r[14:0]) * 30'(sy_r[14:0]);
  assign px3   = 30'(t2x_r) * 30'(sx_r[14:0]);
  assign py3   = 30'(t2y_r) * 30'(sy_r[14:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: acceptance and each of the MUL, SQ and CUBE steps fill their own set of registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd;
      col_r <= col;
      row_r <= row;
      lin_r <= linear_index;
      u_r   <= u_sat;
      v_r   <= v_sat;
      wd_r  <= wdata;
      w_r   <= w_side;
      h_r   <= h_side;
    end
    if (state_r == FS_MUL) begin
      sx_r  <= 24'(u_r) * 24'(wm1);
      sy_r  <= 24'(v_r) * 24'(hm1);
      rw_r  <= 16'(row_r) * 16'(w_r);
      len_r <= 16'(w_r) * 16'(h_r);
    end
    if (state_r == FS_SQ) begin
      t2x_r <= px2[29:15];
      t2y_r <= py2[29:15];
      ix_r  <= sx_r[22:15];
      iy_r  <= sy_r[22:15];
      ix1_r <= (ixp1 > {1'b0, wm1}) ? wm1 : ixp1[7:0];
      iy1_r <= (iyp1 > {1'b0, hm1}) ? hm1 : iyp1[7:0];
      nx_r  <= nsx[22:15];
      ny_r  <= nsy[22:15];
      pix_r <= rw_r + 16'(col_r);
      if (cmd_r == CMD_WRITE_XY || cmd_r == CMD_READ_XY) begin
        inside_r <= ({1'b0, col_r} < w_r) && ({1'b0, row_r} < h_r);
      end else begin
        inside_r <= 16'(lin_r) < len_r;
      end
    end
    if (state_r == FS_CUBE) begin
      t3x_r <= px3[29:15];
      t3y_r <= py3[29:15];
      yw0_r <= 16'(iy_r) * 16'(w_r);
      yw1_r <= 16'(iy1_r) * 16'(w_r);
      nyw_r <= 16'(ny_r) * 16'(w_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: if (accept) state_nxt = FS_MUL;
      FS_MUL:  state_nxt = FS_SQ;
      FS_SQ:   state_nxt = FS_CUBE;
      FS_CUBE: state_nxt = FS_WGT;
      FS_WGT:  if (!has_push || !q_stat.full) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    ent       = '0;
    ent.kind  = EK_READ;
    ent.wdata = wd_r;
    has_push  = 1'b0;
    unique case (cmd_r)
      CMD_WRITE_XY, CMD_WRITE_LIN: begin
        // Writes outside the image are dropped here.
        has_push    = inside_r;
        ent.kind    = EK_WRITE;
        ent.addr[0] = (cmd_r == CMD_WRITE_XY) ? pix_r : 16'(lin_r);
      end
      CMD_READ_XY, CMD_READ_LIN: begin
        has_push    = 1'b1;
        ent.zero    = !inside_r;
        ent.addr[0] = (cmd_r == CMD_READ_XY) ? pix_r : 16'(lin_r);
      end
      CMD_NEAREST: begin
        has_push    = 1'b1;
        ent.addr[0] = nyw_r + 16'(nx_r);
      end
      CMD_BILINEAR: begin
        has_push    = 1'b1;
        ent.kind    = EK_BILIN;
        ent.addr[0] = yw0_r + 16'(ix_r);
        ent.addr[1] = yw0_r + 16'(ix1_r);
        ent.addr[2] = yw1_r + 16'(ix_r);
        ent.addr[3] = yw1_r + 16'(ix1_r);
        ent.wgt_x   = smooth_wgt(t2x_r, t3x_r);
        ent.wgt_y   = smooth_wgt(t2y_r, t3y_r);
      end
      default: has_push = 1'b0;
    endcase
  end

  assign push      = (state_r == FS_WGT) && has_push && !q_stat.full;
  assign push_data = ent;
  assign busy      = (state_r != FS_IDLE);

endmodule

>>> rtl/tsbs_back.sv
`timescale 1ns / 1ps
module tsbs_back
  import tsbs_pkg::*;
#(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
  parameter int DEPTH        = DEF_MAX_SIDE * DEF_MAX_SIDE
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_stat_t                q_stat,
  input  entry_t                 pop_data,
  output logic                   pop,
  output logic                   out_valid,
  output logic [3:0][CHAN_W-1:0] out_chan,
  output logic                   busy
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CB     = CHANNEL_BITS;
  localparam int PW     = CB + 17;

  back_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]    clr_cnt_r;
  entry_t               ent_r;
  logic [1:0]           idx_r;
  logic [3:0][4*CB-1:0] pix_r;
  logic [3:0][CB-1:0]   top_r, bot_r, res_r;
  logic                 out_valid_r;

  logic                 ram_en, ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [4*CB-1:0]      ram_wdata, ram_rdata;
  logic [1:0]           last_idx;
  logic [15:0]          ax, ay;
  logic [3:0][PW-1:0]   sum_top, sum_bot, sum_mix;

  tsbs_ram #(
    .WIDTH(4*CB),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign last_idx = (ent_r.kind == EK_BILIN) ? 2'd3 : 2'd0;
  assign ax = 16'(17'(Q15_ONE) - 17'(ent_r.wgt_x));
  assign ay = 16'(17'(Q15_ONE) - 17'(ent_r.wgt_y));

  // pix_r holds whole pixels; channel k of a pixel sits at bit k*CB.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_top[k] = PW'(ax) * PW'(pix_r[0][k*CB +: CB])
                 + PW'(ent_r.wgt_x) * PW'(pix_r[1][k*CB +: CB]);
      sum_bot[k] = PW'(ax) * PW'(pix_r[2][k*CB +: CB])
                 + PW'(ent_r.wgt_x) * PW'(pix_r[3][k*CB +: CB]);
      sum_mix[k] = PW'(ay) * PW'(top_r[k]) + PW'(ent_r.wgt_y) * PW'(bot_r[k]);
    end
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = ADDR_W'(ent_r.addr[idx_r]);
    ram_wdata = '0;
    unique case (state_r)
      BS_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
      end
      BS_WRITE: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = ADDR_W'(ent_r.addr[0]);
        for (int k = 0; k < 4; k++) begin
          ram_wdata[k*CB +: CB] = ent_r.wdata[k][CB-1:0];
        end
      end
      BS_FETCH: ram_en = 1'b1;
      default: ram_en = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_CLEAR: if (clr_cnt_r == ADDR_W'(DEPTH-1)) state_nxt = BS_IDLE;
      BS_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (pop_data.kind == EK_WRITE) ? BS_WRITE : BS_FETCH;
        end
      end
      BS_WRITE: state_nxt = BS_IDLE;
      BS_FETCH: if (idx_r == last_idx) state_nxt = BS_LAST;
      BS_LAST:  state_nxt = (ent_r.kind == EK_BILIN) ? BS_ROW : BS_IDLE;
      BS_ROW:   state_nxt = BS_MIX;
      BS_MIX:   state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  assign pop = (state_r == BS_IDLE) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CLEAR;
      clr_cnt_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (state_r == BS_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == BS_IDLE) begin
        idx_r <= '0;
      end else if (state_r == BS_FETCH) begin
        idx_r <= idx_r + 2'd1;
      end
      if ((state_r == BS_LAST && ent_r.kind != EK_BILIN) || state_r == BS_MIX) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Read data arrives in the cycle after its address, so each fetch step after
  // the first, and the last step, stores the pixel requested in the step before.
  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= pop_data;
    end
    if (state_r == BS_FETCH && idx_r != 2'd0) begin
      pix_r[idx_r - 2'd1] <= ram_rdata;
    end
    if (state_r == BS_LAST) begin
      pix_r[last_idx] <= ram_rdata;
      for (int k = 0; k < 4; k++) begin
        res_r[k] <= ent_r.zero ? '0 : ram_rdata[k*CB +: CB];
      end
    end
    if (state_r == BS_ROW) begin
      for (int k = 0; k < 4; k++) begin
        top_r[k] <= sum_top[k][15 +: CB];
        bot_r[k] <= sum_bot[k][15 +: CB];
      end
    end
    if (state_r == BS_MIX) begin
      for (int k = 0; k < 4; k++) begin
        res_r[k] <= sum_mix[k][15 +: CB];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      out_chan[k] = CHAN_W'(res_r[k]);
    end
  end

  assign out_valid = out_valid_r;
  assign busy      = (state_r != BS_IDLE);

endmodule

>>> rtl/tsbs_checker.sv
`timescale 1ns / 1ps
`include "texture_store_bilinear_sampler_core_assert.svh"
module tsbs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // Requests are served one at a time, so results never come back to back.
  `TSBS_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `TSBS_ASSERT_NEXT(a_busy_after_req, clk, rst_n, start && !busy, busy, "not busy after request")
  `TSBS_ASSERT_NEXT(a_no_instant_result, clk, rst_n, start && !busy, !out_valid,
                    "result one cycle after request")
  `TSBS_ASSERT_SAME(a_idle_with_result, clk, rst_n, out_valid, !busy, "busy while result shown")

endmodule

bind texture_store_bilinear_sampler_core tsbs_checker u_tsbs_checker (.*);
